// File: hw/rtl/hav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_pkg
// Shared types, op codes and helpers for the height availability scoreboard.
// ----------------------------------------------------------------------------
package hav_pkg;

	localparam logic [2:0] OP_MARK    = 3'd0;
	localparam logic [2:0] OP_QUERY   = 3'd1;
	localparam logic [2:0] OP_ADVANCE = 3'd2;
	localparam logic [2:0] OP_RUN     = 3'd3;
	localparam logic [2:0] OP_MISSING = 3'd4;
	localparam logic [2:0] OP_COUNT   = 3'd5;
	localparam logic [2:0] OP_RESTART = 3'd6;

	localparam logic [31:0] HEIGHT_MAX = 32'hFFFF_FFFF;
	localparam logic [16:0] CNT_MAX    = 17'h1_FFFF;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] height;
	} item_t;

	typedef struct packed {
		logic        status;
		logic        found;
		logic [31:0] first_height;
		logic [31:0] last_height;
		logic [16:0] run_length;
		logic [16:0] present_count;
		logic [16:0] missing_count;
	} result_t;

	// Summary of one memory word inside the active bit window (words up to 64 bits)
	typedef struct packed {
		logic [6:0] ones;
		logic       zero_hit;
		logic [5:0] zero_off;
	} word_eval_t;

	function automatic logic [16:0] sat17(input logic [31:0] v);
		logic [16:0] r;
		r = (v > 32'(CNT_MAX)) ? CNT_MAX : v[16:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/hav_word_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_word_eval
// Builds the bit window of one bitmap word, counts its set bits and finds
// its lowest clear bit.
// ----------------------------------------------------------------------------
module hav_word_eval #(
	parameter int WORD_BITS = 64
) (
	input  logic [WORD_BITS-1:0]         data,
	input  logic [$clog2(WORD_BITS)-1:0] lo_off,
	input  logic [$clog2(WORD_BITS)-1:0] hi_off,
	output logic [WORD_BITS-1:0]         mask,
	output hav_pkg::word_eval_t          eval
);

	localparam int WB = $clog2(WORD_BITS);

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = (WB'(i) >= lo_off) && (WB'(i) <= hi_off);
		end
	end

	always_comb begin
		eval = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			eval.ones = eval.ones + 7'(data[i] & mask[i]);
		end
		// scan from the top so the lowest clear bit wins
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (mask[i] && !data[i]) begin
				eval.zero_hit = 1'b1;
				eval.zero_off = 6'(i);
			end
		end
	end

endmodule

// File: hw/rtl/hav_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_engine
// Bitmap memory with a read-modify-write sequencer that walks words for
// marks, queries, tip advances, run and gap searches, counts and clears.
// ----------------------------------------------------------------------------
module hav_engine #(
	parameter int MAP_BITS  = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_value,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hav_pkg::item_t       in_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output hav_pkg::result_t     res
);

	localparam int WORDS = MAP_BITS / WORD_BITS;
	localparam int WB    = $clog2(WORD_BITS);
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = $clog2(MAP_BITS) + 1;
	localparam logic [31:0] MAP_LIMIT = 32'(MAP_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EV    = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic [2:0]     state_q;
	logic [2:0]     op_q;
	logic [31:0]    h_q;
	logic [31:0]    lo_q;
	logic [31:0]    hi_q;
	logic [31:0]    total_q;
	logic [31:0]    tip_q;
	logic [31:0]    hiseen_q;
	logic [AW-1:0]  cur_q;
	logic [CW-1:0]  acc_q;
	logic           pend_q;
	hav_pkg::result_t res_q;

	logic [WB-1:0]        lo_off;
	logic [WB-1:0]        hi_off;
	logic                 is_last;
	logic [WORD_BITS-1:0] mask;
	hav_pkg::word_eval_t  ev;
	logic [31:0]          m_pos;
	logic [CW-1:0]        acc_next;
	logic                 mem_we;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [31:0]          in_h;
	logic [31:0]          tip_inc;

	assign in_h    = in_item.height;
	assign tip_inc = tip_q + 32'd1;

	assign lo_off  = (cur_q == lo_q[WB +: AW]) ? lo_q[WB-1:0] : '0;
	assign is_last = (cur_q == hi_q[WB +: AW]);
	assign hi_off  = is_last ? hi_q[WB-1:0] : '1;

	hav_word_eval #(.WORD_BITS(WORD_BITS)) u_eval (
		.data   (rdata_q),
		.lo_off (lo_off),
		.hi_off (hi_off),
		.mask   (mask),
		.eval   (ev)
	);

	assign m_pos    = ev.zero_hit ? ((32'(cur_q) << WB) | 32'(ev.zero_off)) : hi_q + 32'd1;
	assign acc_next = acc_q + CW'(ev.ones);

	assign mem_we = (state_q == S_CLEAR) ||
		((state_q == S_EV) && ((op_q == hav_pkg::OP_MARK) || (op_q == hav_pkg::OP_ADVANCE)));
	assign mem_wdata = (state_q == S_CLEAR) ? '0 :
		(op_q == hav_pkg::OP_MARK) ? (rdata_q | mask) : (rdata_q & ~mask);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cur_q] <= mem_wdata;
		end
		rdata_q <= mem[cur_q];
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cur_q    <= '0;
			tip_q    <= '0;
			hiseen_q <= '0;
			pend_q   <= 1'b0;
		end else if (cfg_we) begin
			tip_q    <= cfg_value;
			hiseen_q <= cfg_value;
			cur_q    <= '0;
			pend_q   <= 1'b0;
			state_q  <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (cur_q == LAST_WORD) begin
						cur_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= pend_q ? S_DONE : S_IDLE;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_item.op;
						h_q     <= in_h;
						res_q   <= '0;
						acc_q   <= '0;
						state_q <= S_DONE;
						case (in_item.op)
							hav_pkg::OP_MARK: begin
								if (in_h > tip_q) begin
									if (in_h >= MAP_LIMIT) begin
										res_q.status <= 1'b1;
									end else begin
										lo_q    <= in_h;
										hi_q    <= in_h;
										cur_q   <= in_h[WB +: AW];
										state_q <= S_RD;
									end
								end
							end
							hav_pkg::OP_QUERY: begin
								if (in_h <= tip_q) begin
									res_q.found <= 1'b1;
								end else if (in_h < MAP_LIMIT) begin
									lo_q    <= in_h;
									hi_q    <= in_h;
									cur_q   <= in_h[WB +: AW];
									state_q <= S_RD;
								end
							end
							hav_pkg::OP_ADVANCE: begin
								if (in_h > tip_q) begin
									if (tip_q >= MAP_LIMIT - 32'd1) begin
										tip_q <= in_h;
									end else begin
										lo_q    <= tip_inc;
										hi_q    <= (in_h >= MAP_LIMIT) ? MAP_LIMIT - 32'd1 : in_h;
										cur_q   <= tip_inc[WB +: AW];
										state_q <= S_RD;
									end
								end
							end
							hav_pkg::OP_RUN, hav_pkg::OP_MISSING: begin
								if (tip_q != hav_pkg::HEIGHT_MAX) begin
									if (tip_q < hiseen_q) begin
										lo_q    <= tip_inc;
										hi_q    <= hiseen_q;
										cur_q   <= tip_inc[WB +: AW];
										state_q <= S_RD;
									end else if (in_item.op == hav_pkg::OP_MISSING) begin
										res_q.found        <= 1'b1;
										res_q.first_height <= tip_inc;
									end
								end
							end
							hav_pkg::OP_COUNT: begin
								if (hiseen_q > tip_q) begin
									lo_q    <= tip_inc;
									hi_q    <= hiseen_q;
									total_q <= hiseen_q - tip_q;
									cur_q   <= tip_inc[WB +: AW];
									state_q <= S_RD;
								end
							end
							hav_pkg::OP_RESTART: begin
								tip_q    <= in_h;
								hiseen_q <= in_h;
								cur_q    <= '0;
								pend_q   <= 1'b1;
								state_q  <= S_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					state_q <= S_DONE;
					case (op_q)
						hav_pkg::OP_MARK: begin
							if (h_q > hiseen_q) begin
								hiseen_q <= h_q;
							end
						end
						hav_pkg::OP_QUERY: begin
							res_q.found <= |(rdata_q & mask);
						end
						hav_pkg::OP_ADVANCE: begin
							if (is_last) begin
								tip_q <= h_q;
							end else begin
								cur_q   <= cur_q + AW'(1);
								state_q <= S_RD;
							end
						end
						hav_pkg::OP_RUN, hav_pkg::OP_MISSING: begin
							if (ev.zero_hit || is_last) begin
								if (op_q == hav_pkg::OP_MISSING) begin
									res_q.found        <= 1'b1;
									res_q.first_height <= m_pos;
								end else if (m_pos != lo_q) begin
									res_q.found        <= 1'b1;
									res_q.first_height <= lo_q;
									res_q.last_height  <= m_pos - 32'd1;
									res_q.run_length   <= hav_pkg::sat17(m_pos - lo_q);
								end
							end else begin
								cur_q   <= cur_q + AW'(1);
								state_q <= S_RD;
							end
						end
						hav_pkg::OP_COUNT: begin
							acc_q <= acc_next;
							if (is_last) begin
								res_q.present_count <= hav_pkg::sat17(32'(acc_next));
								res_q.missing_count <= hav_pkg::sat17(total_q - 32'(acc_next));
							end else begin
								cur_q   <= cur_q + AW'(1);
								state_q <= S_RD;
							end
						end
						default: begin
						end
					endcase
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/height_availability_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_availability_scoreboard
// Bitmap scoreboard of arrived heights above a validated tip.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  tuser op, tdata height
// m_       out        m_tvalid/m_tready  tdata result fields
// cfg_     in         cfg_valid/ready    cfg_data start tip (restarts store)
//
// Marks and queries that touch the bitmap pass a memory read, an evaluate/write
// and a hand-off to the output register. Items settled without a memory access
// go straight to the hand-off. Advance, run, missing and count scans repeat the
// read and evaluate steps for each bitmap word walked, then hand off; the
// single-port bitmap memory sets the pace. Restart and configuration clear the
// memory at one word per cycle (also after reset) while input is held off. A
// stalled result waits in the output register; the next item may transfer
// meanwhile.
// ----------------------------------------------------------------------------
module height_availability_scoreboard #(
	parameter int MAP_BITS  = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,   // op
	input  logic [31:0]  s_tdata,   // height
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // status, found, first_height, last_height,
	                                // run_length, present_count, missing_count, pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	hav_pkg::item_t   item;
	hav_pkg::result_t res;
	logic             res_valid;
	logic             res_ready;
	logic             out_valid_q;
	hav_pkg::result_t out_q;

	assign cfg_ready   = 1'b1;
	assign item.op     = s_tuser;
	assign item.height = s_tdata;

	hav_engine #(.MAP_BITS(MAP_BITS), .WORD_BITS(WORD_BITS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_value (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.missing_count, out_q.present_count, out_q.run_length,
		out_q.last_height, out_q.first_height, out_q.found, out_q.status};

	// a configuration write starts a clearing pass that holds off input
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> !s_tready)
		else $error("input ready right after configuration write");

	// one item at a time in the engine
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in flight");

	// out-of-capacity marks never report presence
	a_status_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("status and found both set");

endmodule
